// ----- rtl/core/assert_macros.svh -----
// assert_macros.svh: assertion macros used by the checker file pat_checker
// no dependencies; the using module must have clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising edge of clk, skipped while rst is high
`define PAT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// property checked on the rising edge of clk, also during reset
`define PAT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- rtl/core/pat_pkg.sv -----
// pat_pkg: constants, codes and types of the pending ack table
// no dependencies; used by every module of the block but pat_ram
`default_nettype none

package pat_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int COUNT_OUT_W = 5;

  localparam logic [31:0] AGE_LIMIT_RESET = 32'(10 * 60);

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_FIND   = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMATCH = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [7:0]  ack;
    logic [31:0] contact;
    logic [31:0] param;
    logic [31:0] created;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // verdict of the compare unit on one table entry
  typedef struct packed {
    logic hit;    // first entry whose sequence number matches
    logic purge;  // aged entry dropped by a remove
    logic drop;   // entry leaves the table
  } decision_t;

endpackage

`default_nettype wire

// ----- rtl/core/pat_ram.sv -----
// pat_ram: generic single write port, single read port ram, registered read
// no dependencies
`default_nettype none

module pat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/pat_entry_unit.sv -----
// pat_entry_unit: shared compare unit, judges one table entry per cycle
// depends on pat_pkg
`default_nettype none

module pat_entry_unit (
  input  wire pat_pkg::entry_t    entry,
  input  wire logic [31:0]        key,
  input  wire logic [31:0]        limit,
  input  wire logic               matched,
  input  wire logic               remove,
  output pat_pkg::decision_t      dec
);

  logic seq_eq;
  logic aged;

  always_comb begin
    seq_eq    = (entry.seq == key);
    aged      = (entry.created < limit);
    // only the oldest match counts, later matches are ordinary entries
    dec.hit   = seq_eq && !matched;
    dec.purge = remove && aged && !dec.hit;
    dec.drop  = dec.hit || dec.purge;
  end

endmodule

`default_nettype wire

// ----- rtl/core/pending_ack_table_with_aging_unit.sv -----
// pending_ack_table_with_aging_unit: top level of the pending ack table
// depends on pat_pkg, pat_ram, pat_entry_unit
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   in       | in_valid / in_ready  | req_type seq_number ack_kind
//            |                      | contact_handle user_param now_seconds
//   out      | out_valid / out_ready| status found found_ack_kind found_contact
//            |                      | found_param found_created purged_count
//            |                      | entries_now
//   cfg      | cfg_valid / cfg_ready| age_limit_seconds
//
// one request at a time; in_ready is high only while the sequencer is idle
// add: passes the add state (write unless full), then the emit state; unused code: emit only
// find and remove: a scan over the table ram, then emit (emit only on an empty
//   table), with one entry judged by the compare unit per cycle
// a finished result sits in the output register; the sequencer holds in its
//   emit state only while an earlier result is still not taken
// rst is synchronous; the table needs no clearing pass, only the count clears
`default_nettype none

module pending_ack_table_with_aging_unit (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [31:0] seq_number,
  input  wire logic [7:0]  ack_kind,
  input  wire logic [31:0] contact_handle,
  input  wire logic [31:0] user_param,
  input  wire logic [31:0] now_seconds,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic             found,
  output logic [7:0]       found_ack_kind,
  output logic [31:0]      found_contact,
  output logic [31:0]      found_param,
  output logic [31:0]      found_created,
  output logic [pat_pkg::COUNT_OUT_W-1:0] purged_count,
  output logic [pat_pkg::COUNT_OUT_W-1:0] entries_now,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] age_limit_seconds
);

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADD  = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // control state
  logic [pat_pkg::CNT_W-1:0] count;     // entries held
  logic [pat_pkg::CNT_W-1:0] rd_idx;    // next entry to read
  logic [pat_pkg::CNT_W-1:0] wr_idx;    // next compacted slot
  logic [pat_pkg::CNT_W-1:0] purged;
  logic                      rd_vld;    // ram data holds entry rd_idx - 1
  logic                      matched;
  logic [31:0]               age_limit;

  // request captured at the input transfer
  logic [1:0]      req;
  logic [31:0]     key;
  logic [7:0]      new_ack;
  logic [31:0]     new_contact;
  logic [31:0]     new_param;
  logic [31:0]     new_now;
  logic [31:0]     limit;

  // result being built
  pat_pkg::status_t st;
  logic [7:0]       f_ack;
  logic [31:0]      f_contact;
  logic [31:0]      f_param;
  logic [31:0]      f_created;

  // ram and compare unit
  logic                        ram_we;
  logic [pat_pkg::IDX_W-1:0]   ram_waddr;
  pat_pkg::entry_t             ram_wdata;
  pat_pkg::entry_t             new_entry;
  logic [pat_pkg::ENTRY_W-1:0] rd_data;
  pat_pkg::entry_t             rd_entry;
  pat_pkg::decision_t          dec;

  logic accept;
  logic issue;
  logic scan_done;
  logic keep;
  logic full;
  logic is_remove;
  logic load;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  assign full      = (count == pat_pkg::CNT_W'(pat_pkg::TABLE_DEPTH));
  assign is_remove = (req == pat_pkg::REQ_REMOVE);
  assign issue     = (state == S_SCAN) && (rd_idx < count);
  assign scan_done = (state == S_SCAN) && !issue && !rd_vld;
  // surviving entries of a remove are written back in order
  assign keep      = rd_vld && is_remove && !dec.drop;
  assign load      = (state == S_EMIT) && (!out_valid || out_ready);
  assign rd_entry  = pat_pkg::entry_t'(rd_data);

  always_comb begin
    new_entry.seq     = key;
    new_entry.ack     = new_ack;
    new_entry.contact = new_contact;
    new_entry.param   = new_param;
    new_entry.created = new_now;
  end

  always_comb begin
    ram_we    = ((state == S_ADD) && !full) || keep;
    ram_waddr = (state == S_ADD) ? count[pat_pkg::IDX_W-1:0]
                                 : wr_idx[pat_pkg::IDX_W-1:0];
    ram_wdata = (state == S_ADD) ? new_entry : rd_entry;
  end

  pat_ram #(
    .WIDTH (pat_pkg::ENTRY_W),
    .DEPTH (pat_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx[pat_pkg::IDX_W-1:0]),
    .rdata (rd_data)
  );

  pat_entry_unit u_entry (
    .entry   (rd_entry),
    .key     (key),
    .limit   (limit),
    .matched (matched),
    .remove  (is_remove),
    .dec     (dec)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            pat_pkg::REQ_ADD:    state_next = S_ADD;
            pat_pkg::REQ_FIND,
            pat_pkg::REQ_REMOVE: state_next = (count == '0) ? S_EMIT : S_SCAN;
            default:             state_next = S_EMIT;
          endcase
        end
      end
      S_ADD:  state_next = S_EMIT;
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_idx    <= '0;
      wr_idx    <= '0;
      purged    <= '0;
      rd_vld    <= 1'b0;
      matched   <= 1'b0;
      out_valid <= 1'b0;
      age_limit <= pat_pkg::AGE_LIMIT_RESET;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (cfg_valid && cfg_ready) begin
        age_limit <= age_limit_seconds;
      end
      if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            rd_idx  <= '0;
            wr_idx  <= '0;
            purged  <= '0;
            matched <= 1'b0;
          end
        end
        S_ADD: begin
          if (!full) begin
            count <= count + 1'b1;
          end
        end
        S_SCAN: begin
          if (rd_vld) begin
            if (dec.hit) begin
              matched <= 1'b1;
            end
            if (dec.purge) begin
              purged <= purged + 1'b1;
            end
            if (keep) begin
              wr_idx <= wr_idx + 1'b1;
            end
          end
          if (scan_done && is_remove) begin
            count <= wr_idx;
          end
        end
        S_EMIT: ;
        default: ;
      endcase
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req         <= req_type;
      key         <= seq_number;
      new_ack     <= ack_kind;
      new_contact <= contact_handle;
      new_param   <= user_param;
      new_now     <= now_seconds;
      // purge threshold, wraps at 32 bits
      limit       <= now_seconds - age_limit;
      f_ack       <= '0;
      f_contact   <= '0;
      f_param     <= '0;
      f_created   <= '0;
      if (req_type == pat_pkg::REQ_FIND || req_type == pat_pkg::REQ_REMOVE) begin
        st <= pat_pkg::ST_NOMATCH;
      end else begin
        st <= pat_pkg::ST_OK;
      end
    end
    if ((state == S_ADD) && full) begin
      st <= pat_pkg::ST_FULL;
    end
    if ((state == S_SCAN) && rd_vld && dec.hit) begin
      st        <= pat_pkg::ST_OK;
      f_ack     <= rd_entry.ack;
      f_contact <= rd_entry.contact;
      f_param   <= rd_entry.param;
      f_created <= rd_entry.created;
    end
    if (load) begin
      status         <= st;
      found          <= matched;
      found_ack_kind <= f_ack;
      found_contact  <= f_contact;
      found_param    <= f_param;
      found_created  <= f_created;
      purged_count   <= pat_pkg::COUNT_OUT_W'(purged);
      entries_now    <= pat_pkg::COUNT_OUT_W'(count);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pat_checker.sv -----
// pat_checker: port level assertions for the pending ack table, with bind
// depends on pat_pkg, assert_macros.svh, pending_ack_table_with_aging_unit
`default_nettype none

`include "assert_macros.svh"

module pat_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic        found,
  input wire logic [7:0]  found_ack_kind,
  input wire logic [31:0] found_contact,
  input wire logic [31:0] found_param,
  input wire logic [31:0] found_created,
  input wire logic [pat_pkg::COUNT_OUT_W-1:0] entries_now
);

  // a transfer in makes the block busy for at least the next cycle
  `PAT_ASSERT(a_busy_after_transfer, in_valid && in_ready |=> !in_ready, "ready right after transfer")

  // a held result keeps its count
  `PAT_ASSERT(a_hold_result, out_valid && !out_ready |=> out_valid && $stable(entries_now), "result dropped or changed while stalled")

  // a dropped add means the table is at its depth
  `PAT_ASSERT(a_full_count, out_valid && status == pat_pkg::ST_FULL |-> entries_now == pat_pkg::COUNT_OUT_W'(pat_pkg::TABLE_DEPTH), "full status with table not full")

  // no match means empty entry fields
  `PAT_ASSERT(a_found_fields, out_valid && !found |-> found_ack_kind == '0 && found_contact == '0 && found_param == '0 && found_created == '0, "entry fields without a match")

  `PAT_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid, "result valid after reset")

endmodule

bind pending_ack_table_with_aging_unit pat_checker u_pat_checker (.*);

`default_nettype wire
